FILE: hw/rtl/tqs_pkg.sv
// Package for the threshold quantizer search block.
// Holds the float compare helper and the configuration address constants; no dependencies.
package tqs_pkg;

  localparam int unsigned FloatWidth = 32;
  localparam int unsigned CfgAddrWidth = 3;
  localparam logic [CfgAddrWidth-1:0] AddrLevelCount = 3'd0;

  // IEEE single-precision a < b: false on NaN, and -0 equals +0.
  function automatic logic float_lt(input logic [FloatWidth-1:0] a,
                                    input logic [FloatWidth-1:0] b);
    logic a_nan;
    logic b_nan;
    logic both_zero;
    logic res;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (a[31] != b[31]) begin
      res = a[31];
    end else if (a[31]) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    return res && !a_nan && !b_nan && !both_zero;
  endfunction

endpackage

FILE: hw/rtl/threshold_quantizer_search.sv
// Threshold quantizer: binary search of a sample over a float threshold table.
// Depends on tqs_pkg and tqs_ram. Reset is asynchronous, active low; level_count resets
// to 4 and the table is not cleared. Write transactions are accepted back to back.
// A quantize transaction runs probes, each a RAM read and then a compare; the block takes
// no new transaction until its result has been taken, and a stalled result holds it busy.
module threshold_quantizer_search import tqs_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        kind_i,
  input  logic [7:0]  entry_index_i,
  input  logic [31:0] value_bits_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  level_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned Depth = MAX_LEVELS - 1;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LW = $clog2(MAX_LEVELS + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StCmp  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [8:0]  level_count_q;
  logic [LW-1:0] lo_q, lo_d, hi_q, hi_d, n_eff;
  logic [31:0] sample_q;
  logic [AW-1:0] mid;
  logic [31:0] rdata;
  logic        accept, we;
  logic [LW:0] sum;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrLevelCount) ? {23'd0, level_count_q} : 32'd0;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= 9'd4;
    end else if (psel && penable && pwrite && paddr == AddrLevelCount) begin
      level_count_q <= pwdata[8:0];
    end
  end

  // Clamp level_count to MAX_LEVELS, one more than the table size.
  always_comb begin
    if ({23'd0, level_count_q} > MAX_LEVELS) begin
      n_eff = LW'(MAX_LEVELS);
    end else begin
      n_eff = LW'(level_count_q);
    end
  end

  assign stall_o = (state_q != StIdle);
  assign accept  = valid_i && !stall_o;
  assign we      = accept && !kind_i && ({24'd0, entry_index_i} < Depth);
  assign sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = AW'(sum[LW:1]);

  tqs_ram #(.Width(32), .Depth(Depth)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(AW'(entry_index_i)),
    .wdata_i(value_bits_i),
    .raddr_i(mid),
    .rdata_o(rdata)
  );

  // Search sequencer: read the midpoint entry, then narrow the interval.
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    unique case (state_q)
      StIdle: begin
        if (accept && kind_i) begin
          lo_d = '0;
          hi_d = (n_eff <= 1) ? '0 : n_eff - 1'b1;
          state_d = (n_eff <= 1) ? StOut : StRead;
        end
      end
      StRead: begin
        state_d = (lo_q < hi_q) ? StCmp : StOut;
      end
      StCmp: begin
        if (float_lt(sample_q, rdata)) begin
          hi_d = LW'(mid);
        end else begin
          lo_d = LW'(mid) + 1'b1;
        end
        state_d = StRead;
      end
      StOut: begin
        if (!stall_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

  // Sample register, loaded on an accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= value_bits_i;
    end
  end

  assign valid_o = (state_q == StOut);
  assign level_o = 8'(lo_q);

endmodule

FILE: hw/rtl/tqs_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module tqs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 255
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/tqs_checker.sv
// Port-level checker for threshold_quantizer_search, bound to the top level.
// Imports tqs_pkg but uses none of its declarations.
module tqs_checker import tqs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        kind_i,
  input logic        valid_o,
  input logic        stall_i,
  input logic [7:0]  level_o,
  input logic        pready
);

  // A held result keeps its level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(level_o))
    else $error("result changed under stall");

  // The block takes no transaction while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o)
    else $error("input open while result pending");

  // A write transaction yields no result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o && !kind_i |=> !valid_o)
    else $error("result after write");

  // The configuration port never waits.
  assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind threshold_quantizer_search tqs_checker u_tqs_checker (.*);
